[rtl/tage_pkg.sv]
// Shared constants, payload types and controller/datapath interface types for the TAGE predictor.
package tage_pkg;

  localparam int BASE_INDEX_BITS   = 11;
  localparam int TAGGED_INDEX_BITS = 8;
  localparam int TAG_WIDTH         = 11;
  localparam int TAGGED_TABLES     = 7;
  localparam int HISTORY_BITS      = 192;

  localparam int BASE_SIZE = 1 << BASE_INDEX_BITS;
  localparam int TSIZE     = 1 << TAGGED_INDEX_BITS;
  localparam int CLR_BITS  = (BASE_INDEX_BITS > TAGGED_INDEX_BITS) ?
                             BASE_INDEX_BITS : TAGGED_INDEX_BITS;
  localparam int K_BITS    = $clog2(TAGGED_TABLES + 1);
  localparam int PROV_BITS = 3;
  localparam int RND_BITS  = 16;
  localparam int RCNT_BITS = $clog2(RND_BITS);

  localparam int HIST_LEN [7] = '{4, 9, 15, 25, 44, 76, 150};

  localparam logic [2:0] ALLOC_PRED = 3'd4;
  localparam logic [2:0] PRED_MAX   = 3'd7;
  localparam logic [1:0] BASE_RESET = 2'd1;
  localparam logic [1:0] CTR2_MAX   = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [31:0] pc;
    logic        outcome;
    logic [15:0] random_value;
  } req_t;

  typedef struct packed {
    logic       prediction;
    logic [2:0] provider;
  } rsp_t;

  typedef struct packed {
    logic [2:0]           ctr;
    logic [1:0]           u;
    logic [TAG_WIDTH-1:0] tag;
  } tentry_t;

  typedef struct packed {
    logic clr_en;
    logic capture;
    logic load_out;
    logic start_mod;
    logic mod_step;
    logic do_write;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic train;
    logic need_mod;
    logic mod_last;
  } dp_sts_t;

  function automatic logic [31:0] shr_pc(input logic [31:0] pc, input int s);
    shr_pc = (s >= 32) ? 32'd0 : (pc >> s);
  endfunction

endpackage

[rtl/tage_ctrl.sv]
// Sequencing state machine for the TAGE predictor: clear, idle, lookup, remainder, update.
module tage_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  tage_pkg::dp_sts_t sts,
  output tage_pkg::dp_cmd_t cmd
);
  import tage_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_MOD   = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   rsp_free;

  assign req_ready = (state == S_IDLE);
  assign rsp_free  = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        if (rsp_free) begin
          cmd.load_out = 1'b1;
          if (!sts.train) state_next = S_IDLE;
          else if (sts.need_mod) begin
            cmd.start_mod = 1'b1;
            state_next    = S_MOD;
          end else state_next = S_WRITE;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.do_write = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> state == S_LOOK) else $error("accept did not start lookup");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> rsp_valid) else $error("result loaded but not offered");
  a_write_order: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |-> ($past(state) == S_LOOK || $past(state) == S_MOD))
    else $error("update without lookup");
`endif

endmodule

[rtl/tage_dp.sv]
// Datapath for the TAGE predictor: tables, history folds, hashing, remainder unit, result register.
module tage_dp (
  input  logic              clk,
  input  logic              rst,
  input  tage_pkg::req_t    req_data,
  input  tage_pkg::dp_cmd_t cmd,
  output tage_pkg::dp_sts_t sts,
  output tage_pkg::rsp_t    rsp_data
);
  import tage_pkg::*;

  localparam int NT = TAGGED_TABLES;

  logic [1:0] base_mem [BASE_SIZE];
  tentry_t    tmem [NT][TSIZE];

  logic [HISTORY_BITS-1:0]      ghist, hnew;
  logic [TAGGED_INDEX_BITS-1:0] ifold [NT];
  logic [TAGGED_INDEX_BITS-1:0] ifold_next [NT];
  logic [TAG_WIDTH-1:0]         tfold1 [NT];
  logic [TAG_WIDTH-1:0]         tfold1_next [NT];
  logic [TAG_WIDTH-1:0]         tfold2 [NT];
  logic [TAG_WIDTH-1:0]         tfold2_next [NT];

  logic [TAGGED_INDEX_BITS-1:0] idx_in [NT];
  logic [TAG_WIDTH-1:0]         tag_in [NT];
  logic [TAGGED_INDEX_BITS-1:0] idx_q [NT];
  logic [TAG_WIDTH-1:0]         tag_q [NT];
  req_t                         req_q;
  logic [1:0]                   base_rd;
  tentry_t                      trd [NT];

  logic [CLR_BITS-1:0]  clr_cnt;
  logic [NT-1:0]        rem;
  logic [NT:0]          trial;
  logic [RND_BITS-1:0]  rnd_sh;
  logic [RCNT_BITS-1:0] rcnt;

  logic [NT-1:0]        hit, above, elig, sel;
  logic                 prov_v, alt_v, pred, altpred, alloc_en, found;
  logic [PROV_BITS-1:0] prov, alt;
  logic [K_BITS-1:0]    k;
  logic [NT-1:0]        dvs, r;
  tentry_t              tnew [NT];
  logic [NT-1:0]        twe;
  logic [1:0]           base_new;

  // Index and tag hashes from the live folds
  always_comb begin
    for (int t = 0; t < NT; t++) begin
      idx_in[t] = TAGGED_INDEX_BITS'(shr_pc(req_data.pc, HIST_LEN[t]) ^ req_data.pc
                                     ^ 32'(ifold[t]));
      tag_in[t] = TAG_WIDTH'(req_data.pc ^ 32'(tfold1[t]) ^ (32'(tfold2[t]) << 1));
    end
  end

  // Capture the transaction and read every table
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q   <= req_data;
      base_rd <= base_mem[req_data.pc[BASE_INDEX_BITS-1:0]];
      for (int t = 0; t < NT; t++) begin
        idx_q[t] <= idx_in[t];
        tag_q[t] <= tag_in[t];
        trd[t]   <= tmem[t][idx_in[t]];
      end
    end
  end

  // Lookup and update decisions
  always_comb begin
    prov_v = 1'b0;
    alt_v  = 1'b0;
    prov   = '0;
    alt    = '0;
    for (int t = 0; t < NT; t++) begin
      hit[t] = (trd[t].tag == tag_q[t]);
      if (hit[t]) begin
        alt_v  = prov_v;
        alt    = prov;
        prov_v = 1'b1;
        prov   = PROV_BITS'(t);
      end
    end
    pred     = prov_v ? trd[prov].ctr[2] : base_rd[1];
    altpred  = alt_v ? trd[alt].ctr[2] : base_rd[1];
    alloc_en = (req_q.outcome != pred) && !(prov_v && prov == PROV_BITS'(NT - 1));
    for (int t = 0; t < NT; t++) begin
      above[t] = !prov_v || (PROV_BITS'(t) > prov);
      elig[t]  = above[t] && (trd[t].u == 2'd0);
    end
    k = K_BITS'($countones(elig));
    for (int b = 0; b < NT; b++) dvs[b] = (K_BITS'(b) < k);

    // Pick the allocation slot from the remainder bits
    r     = rem;
    found = 1'b0;
    sel   = '0;
    for (int t = 0; t < NT; t++) begin
      if (elig[t] && !found) begin
        if (!r[0]) begin
          sel[t] = 1'b1;
          found  = 1'b1;
        end else r = r >> 1;
      end
    end

    for (int t = 0; t < NT; t++) begin
      tnew[t] = trd[t];
      twe[t]  = 1'b0;
      if (prov_v && prov == PROV_BITS'(t)) begin
        twe[t] = 1'b1;
        if (req_q.outcome) begin
          if (trd[t].ctr != PRED_MAX) tnew[t].ctr = trd[t].ctr + 3'd1;
        end else if (trd[t].ctr != 3'd0) tnew[t].ctr = trd[t].ctr - 3'd1;
        if (pred != altpred) begin
          if (pred == req_q.outcome) begin
            if (trd[t].u != CTR2_MAX) tnew[t].u = trd[t].u + 2'd1;
          end else if (trd[t].u != 2'd0) tnew[t].u = trd[t].u - 2'd1;
        end
      end
      if (alloc_en && k != '0 && sel[t]) begin
        twe[t]      = 1'b1;
        tnew[t].ctr = ALLOC_PRED;
        tnew[t].tag = tag_q[t];
      end
      if (alloc_en && k == '0 && above[t]) begin
        twe[t] = 1'b1;
        if (trd[t].u != 2'd0) tnew[t].u = trd[t].u - 2'd1;
      end
    end

    base_new = base_rd;
    if (req_q.outcome) begin
      if (base_rd != CTR2_MAX) base_new = base_rd + 2'd1;
    end else if (base_rd != 2'd0) base_new = base_rd - 2'd1;
  end

  // Table writes: clearing sweep or training update
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      base_mem[clr_cnt[BASE_INDEX_BITS-1:0]] <= BASE_RESET;
      for (int t = 0; t < NT; t++)
        tmem[t][clr_cnt[TAGGED_INDEX_BITS-1:0]] <= '{ctr: ALLOC_PRED, u: 2'd0, tag: '0};
    end else if (cmd.do_write) begin
      if (!prov_v) base_mem[req_q.pc[BASE_INDEX_BITS-1:0]] <= base_new;
      for (int t = 0; t < NT; t++)
        if (twe[t]) tmem[t][idx_q[t]] <= tnew[t];
    end
  end

  // Restoring remainder by 2^k-1, one random bit a cycle
  assign trial = {rem, rnd_sh[RND_BITS-1]};

  always_ff @(posedge clk) begin
    if (cmd.start_mod) begin
      rem    <= '0;
      rnd_sh <= req_q.random_value;
      rcnt   <= RCNT_BITS'(RND_BITS - 1);
    end else if (cmd.mod_step) begin
      rem    <= (trial >= {1'b0, dvs}) ? NT'(trial - {1'b0, dvs}) : trial[NT-1:0];
      rnd_sh <= rnd_sh << 1;
      rcnt   <= rcnt - RCNT_BITS'(1);
    end
  end

  // History shift and fold update
  always_comb begin
    hnew = {ghist[HISTORY_BITS-2:0], req_q.outcome};
    for (int t = 0; t < NT; t++) begin
      ifold_next[t] = {ifold[t][TAGGED_INDEX_BITS-2:0],
                       ifold[t][TAGGED_INDEX_BITS-1] ^ req_q.outcome};
      ifold_next[t][HIST_LEN[t] % TAGGED_INDEX_BITS] =
        ifold_next[t][HIST_LEN[t] % TAGGED_INDEX_BITS] ^ hnew[HIST_LEN[t]];
      tfold1_next[t] = {tfold1[t][TAG_WIDTH-2:0], tfold1[t][TAG_WIDTH-1] ^ req_q.outcome};
      tfold1_next[t][HIST_LEN[t] % TAG_WIDTH] =
        tfold1_next[t][HIST_LEN[t] % TAG_WIDTH] ^ hnew[HIST_LEN[t]];
      tfold2_next[t] = {tfold2[t][TAG_WIDTH-2:0], tfold2[t][TAG_WIDTH-1] ^ req_q.outcome};
      tfold2_next[t][HIST_LEN[t] % TAG_WIDTH] =
        tfold2_next[t][HIST_LEN[t] % TAG_WIDTH] ^ hnew[HIST_LEN[t]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ghist   <= '0;
      clr_cnt <= '0;
      for (int t = 0; t < NT; t++) begin
        ifold[t]  <= '0;
        tfold1[t] <= '0;
        tfold2[t] <= '0;
      end
    end else begin
      if (cmd.clr_en) clr_cnt <= clr_cnt + CLR_BITS'(1);
      if (cmd.do_write) begin
        ghist <= hnew;
        for (int t = 0; t < NT; t++) begin
          ifold[t]  <= ifold_next[t];
          tfold1[t] <= tfold1_next[t];
          tfold2[t] <= tfold2_next[t];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_data.prediction <= pred;
      rsp_data.provider   <= prov_v ? prov + PROV_BITS'(1) : '0;
    end
  end

  assign sts.clr_last = &clr_cnt;
  assign sts.train    = req_q.kind;
  assign sts.need_mod = alloc_en && (k != '0);
  assign sts.mod_last = (rcnt == '0);

endmodule

[rtl/tage_branch_predictor.sv]
// Top level of the TAGE branch predictor: controller plus datapath.
// The lookup state after acceptance loads the result for either kind of transaction.
// Requests are taken only in idle: a predict runs lookup, a train also update, and an
// allocating train first the 2^k-1 remainder, one bit per cycle in a restoring unit.
// A stalled result holds the lookup state, and with it the input, until the result drains.
// Reset: synchronous; a clearing pass over 2048 entries then initializes the tables.
module tage_branch_predictor (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  tage_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output tage_pkg::rsp_t rsp_data
);
  import tage_pkg::*;

  // Command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: clearing sweep, lookup, remainder, table update
  tage_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Tables, folded history and result register
  tage_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_data (req_data),
    .cmd      (cmd),
    .sts      (sts),
    .rsp_data (rsp_data)
  );

endmodule

[bench/tb_tage_branch_predictor.sv]
// Self-checking testbench for the TAGE branch predictor with a behavioral table model.
module tb_tage_branch_predictor;
  import tage_pkg::*;

  localparam int IDX_MASK = TSIZE - 1;
  localparam int TAG_KEEP = (1 << TAG_WIDTH) - 1;
  localparam int STALL_LIMIT = 20000;

  typedef enum logic {KIND_PREDICT = 1'b0, KIND_TRAIN = 1'b1} kind_e;

  // Behavioral predictor plus the queue of outstanding predictions.
  class tage_scoreboard;
    logic [1:0]           base_ctr [BASE_SIZE];
    logic [2:0]           pred_ctr [TAGGED_TABLES][TSIZE];
    logic [1:0]           use_ctr  [TAGGED_TABLES][TSIZE];
    logic [TAG_WIDTH-1:0] tags     [TAGGED_TABLES][TSIZE];
    logic [HISTORY_BITS-1:0] ghist;
    logic [TAGGED_INDEX_BITS-1:0] ifold [TAGGED_TABLES];
    logic [TAG_WIDTH-1:0] tfold1 [TAGGED_TABLES];
    logic [TAG_WIDTH-1:0] tfold2 [TAGGED_TABLES];
    rsp_t pending [$];
    int   errors;
    int   checked;
    int   allocs;

    function void clear();
      foreach (base_ctr[i]) base_ctr[i] = BASE_RESET;
      for (int t = 0; t < TAGGED_TABLES; t++) begin
        for (int e = 0; e < TSIZE; e++) begin
          pred_ctr[t][e] = ALLOC_PRED;
          use_ctr[t][e] = 2'd0;
          tags[t][e] = '0;
        end
        ifold[t] = '0;
        tfold1[t] = '0;
        tfold2[t] = '0;
      end
      ghist = '0;
      pending.delete();
      errors = 0;
      checked = 0;
      allocs = 0;
    endfunction

    function int fold_next(int r, int bits, int len);
      int mask;
      int lsb;
      mask = (1 << bits) - 1;
      lsb = ((r >> (bits - 1)) & 1) ^ int'(ghist[0]);
      r = ((r << 1) & mask) | lsb;
      if (len < HISTORY_BITS) r ^= int'(ghist[len]) << (len % bits);
      return r & mask;
    endfunction

    // Predict from the longest hit; on train, update counters, allocate, shift history.
    function void note_request(req_t rq);
      int idx [TAGGED_TABLES];
      int tg  [TAGGED_TABLES];
      int prov;
      int alt;
      int bidx;
      int k;
      int r;
      logic pred;
      logic altpred;
      rsp_t res;
      bidx = rq.pc & (BASE_SIZE - 1);
      prov = -1;
      alt = -1;
      for (int i = TAGGED_TABLES - 1; i >= 0; i--) begin
        idx[i] = (shr_pc(rq.pc, HIST_LEN[i]) ^ rq.pc ^ ifold[i]) & IDX_MASK;
        tg[i] = (rq.pc ^ tfold1[i] ^ (tfold2[i] << 1)) & TAG_KEEP;
        if (tags[i][idx[i]] == tg[i]) begin
          if (prov < 0) prov = i;
          else if (alt < 0) alt = i;
        end
      end
      pred = (prov >= 0) ? pred_ctr[prov][idx[prov]][2] : base_ctr[bidx][1];
      altpred = (alt >= 0) ? pred_ctr[alt][idx[alt]][2] : base_ctr[bidx][1];
      res.prediction = pred;
      res.provider = 3'(prov + 1);
      pending.push_back(res);
      if (rq.kind == KIND_PREDICT) return;

      if (prov >= 0 && pred != altpred) begin
        if (pred == rq.outcome) begin
          if (use_ctr[prov][idx[prov]] < CTR2_MAX) use_ctr[prov][idx[prov]]++;
        end else if (use_ctr[prov][idx[prov]] > 0) use_ctr[prov][idx[prov]]--;
      end
      if (prov >= 0) begin
        if (rq.outcome) begin
          if (pred_ctr[prov][idx[prov]] < PRED_MAX) pred_ctr[prov][idx[prov]]++;
        end else if (pred_ctr[prov][idx[prov]] > 0) pred_ctr[prov][idx[prov]]--;
      end else begin
        if (rq.outcome) begin
          if (base_ctr[bidx] < CTR2_MAX) base_ctr[bidx]++;
        end else if (base_ctr[bidx] > 0) base_ctr[bidx]--;
      end

      if (pred != rq.outcome && prov != TAGGED_TABLES - 1) begin
        k = 0;
        for (int i = prov + 1; i < TAGGED_TABLES; i++)
          if (use_ctr[i][idx[i]] == 0) k++;
        if (k > 0) begin
          allocs++;
          r = int'(rq.random_value) % ((1 << k) - 1);
          for (int i = prov + 1; i < TAGGED_TABLES; i++) begin
            if (use_ctr[i][idx[i]] != 0) continue;
            if ((r & 1) == 0) begin
              pred_ctr[i][idx[i]] = ALLOC_PRED;
              tags[i][idx[i]] = tg[i][TAG_WIDTH-1:0];
              break;
            end
            r >>= 1;
          end
        end else begin
          for (int i = prov + 1; i < TAGGED_TABLES; i++)
            if (use_ctr[i][idx[i]] > 0) use_ctr[i][idx[i]]--;
        end
      end

      ghist = {ghist[HISTORY_BITS-2:0], rq.outcome};
      for (int i = 0; i < TAGGED_TABLES; i++) begin
        ifold[i] = TAGGED_INDEX_BITS'(fold_next(ifold[i], TAGGED_INDEX_BITS, HIST_LEN[i]));
        tfold1[i] = TAG_WIDTH'(fold_next(tfold1[i], TAG_WIDTH, HIST_LEN[i]));
        tfold2[i] = TAG_WIDTH'(fold_next(tfold2[i], TAG_WIDTH, HIST_LEN[i]));
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result prediction=%0d provider=%0d",
                 $time, got.prediction, got.provider);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.prediction !== want.prediction) begin
        $display("%0t: prediction mismatch expected %0d actual %0d",
                 $time, want.prediction, got.prediction);
        errors++;
      end
      if (got.provider !== want.provider) begin
        $display("%0t: provider mismatch expected %0d actual %0d",
                 $time, want.provider, got.provider);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  tage_scoreboard board = new();

  // Idle/stall rates in percent, changed per phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;
  int sent_items = 0;
  int train_items = 0;

  tage_branch_predictor dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data(rsp_data)
  );

  always #6 clk = ~clk;

  // Model transactions at the edge, before the nonblocking drives land.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) board.note_request(req_data);
      if (rsp_valid && rsp_ready) board.check_result(rsp_data);
    end
  end

  // Receiver: random stalls, or a long hold-off when the pressure phase asks.
  always @(posedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", idle_cycles);
      $display("FAIL tage_branch_predictor");
      $finish;
    end
  end

  // Offer one transaction, keeping valid high back to back when no idle is drawn.
  task automatic send_item(req_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= rq;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent_items++;
    if (rq.kind == KIND_TRAIN) train_items++;
  endtask

  // Drop valid for one cycle so the next drive lands at a later edge.
  task automatic release_valid();
    req_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic req_t make_item(logic kind, logic [31:0] pc, logic outcome,
                                     logic [15:0] rnd);
    req_t rq;
    rq.kind = kind;
    rq.pc = pc;
    rq.outcome = outcome;
    rq.random_value = rnd;
    return rq;
  endfunction

  // Mostly trains on a small pool of branches so tagged entries hit and age.
  task automatic random_phase(int count, int idle_pct, int stall_pct);
    logic [31:0] pool [16];
    logic [31:0] pc;
    logic kind;
    logic outcome;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    foreach (pool[i]) pool[i] = $urandom();
    for (int n = 0; n < count; n++) begin
      pc = ($urandom_range(99) < 80) ? pool[$urandom_range(15)] : $urandom();
      kind = ($urandom_range(99) < 75);
      // Follow a per-branch pattern with occasional flips to force mispredicts.
      outcome = ($urandom_range(99) < 70) ? pc[3] ^ pc[n % 7] : 1'($urandom_range(1));
      send_item(make_item(kind, pc, outcome, 16'($urandom())));
    end
    release_valid();
  endtask

  initial begin
    int guard;
    board.clear();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme pcs and random values, both kinds, both outcomes.
    send_item(make_item(KIND_PREDICT, 32'h0000_0000, 1'b0, 16'h0000));
    send_item(make_item(KIND_PREDICT, 32'hFFFF_FFFF, 1'b1, 16'hFFFF));
    send_item(make_item(KIND_TRAIN, 32'h0000_0000, 1'b1, 16'h0000));
    send_item(make_item(KIND_TRAIN, 32'hFFFF_FFFF, 1'b1, 16'hFFFF));
    send_item(make_item(KIND_TRAIN, 32'hFFFF_FFFF, 1'b0, 16'h5555));
    send_item(make_item(KIND_TRAIN, 32'h8000_0001, 1'b0, 16'hAAAA));
    // Repeated branch: saturate counters up then down, hitting allocation.
    for (int i = 0; i < 6; i++)
      send_item(make_item(KIND_TRAIN, 32'h1234_5678, 1'b1, 16'(i * 9001)));
    for (int i = 0; i < 6; i++)
      send_item(make_item(KIND_TRAIN, 32'h1234_5678, 1'b0, 16'(i * 7717)));
    send_item(make_item(KIND_PREDICT, 32'h1234_5678, 1'b0, 16'h0001));
    release_valid();

    random_phase(500, 0, 0);
    random_phase(450, 58, 0);
    random_phase(450, 0, 58);
    random_phase(400, 32, 32);

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(60, 0, 0);
    join
    random_phase(70, 0, 0);

    guard = 0;
    while (board.pending.size() != 0 && guard < STALL_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);

    $display("sent %0d transactions (%0d trains, %0d allocations), checked %0d results",
             sent_items, train_items, board.allocs, board.checked);
    $display("idle/stall phases and a long receiver hold-off exercised");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS tage_branch_predictor");
    end else begin
      $display("%0d mismatches, %0d results missing", board.errors, board.pending.size());
      $display("FAIL tage_branch_predictor");
    end
    $finish;
  end

endmodule
